/* hw/rtl/ubc_pkg.sv */
// shared types and constants of the unaligned bit copy engine
package ubc_pkg;

   localparam int STORE_BYTES = 256;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int BIT_W       = ADDR_W + 3;
   localparam int LEN_W       = BIT_W + 1;
   localparam int BIT_LIMIT   = STORE_BYTES * 8;

   typedef enum logic [1:0] {
      CMD_WR_SRC = 2'd0,
      CMD_WR_DST = 2'd1,
      CMD_RD_DST = 2'd2,
      CMD_COPY   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY_RD,
      ST_COPY_WR
   } state_type;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   // store access request from the sequencer
   typedef struct packed {
      logic              src_we;
      logic              dst_we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic [ADDR_W-1:0] src_raddr_lo;
      logic [ADDR_W-1:0] src_raddr_hi;
      logic [ADDR_W-1:0] dst_raddr;
   } mem_req_type;

   // funnel shift and merge control
   typedef struct packed {
      logic [2:0] shift;
      logic [7:0] mask;
   } merge_ctl_type;

   // result load into the output register
   typedef struct packed {
      logic       load;
      logic [7:0] read_data;
      logic       status;
   } rsp_load_type;

endpackage

/* hw/rtl/ubc_stores.sv */
// source and destination byte stores with registered reads
module ubc_stores
   import ubc_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  src_lo,
   output logic [7:0]  src_hi,
   output logic [7:0]  dst_rd
);

   logic [7:0] src_mem [STORE_BYTES];
   logic [7:0] dst_mem [STORE_BYTES];
   logic [7:0] src_lo_ff;
   logic [7:0] src_hi_ff;
   logic [7:0] dst_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_req.src_we) begin
         src_mem[mem_req.waddr] <= mem_req.wdata;
      end
      src_lo_ff <= src_mem[mem_req.src_raddr_lo];
      src_hi_ff <= src_mem[mem_req.src_raddr_hi];
   end

   always_ff @(posedge clock) begin
      if (mem_req.dst_we) begin
         dst_mem[mem_req.waddr] <= mem_req.wdata;
      end
      dst_rd_ff <= dst_mem[mem_req.dst_raddr];
   end

   assign src_lo = src_lo_ff;
   assign src_hi = src_hi_ff;
   assign dst_rd = dst_rd_ff;

endmodule

/* hw/rtl/ubc_funnel.sv */
// funnel shifter and bit merge for one destination byte
module ubc_funnel
   import ubc_pkg::*;
(
   input  merge_ctl_type ctl,
   input  logic [7:0]    src_lo,
   input  logic [7:0]    src_hi,
   input  logic [7:0]    dst_old,
   output logic [7:0]    dst_new
);

   logic [15:0] pair;
   logic [7:0]  aligned;

   always_comb begin
      pair    = {src_hi, src_lo} >> ctl.shift;
      aligned = pair[7:0];
      // bits outside the run keep their old value
      dst_new = (aligned & ctl.mask) | (dst_old & ~ctl.mask);
   end

endmodule

/* hw/rtl/ubc_seq.sv */
// command sequencer: byte commands and the per-byte copy walk
module ubc_seq
   import ubc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  cmd_type       cmd,
   input  logic [7:0]    byte_addr,
   input  logic [7:0]    byte_data,
   input  logic [10:0]   src_bit_addr,
   input  logic [10:0]   dst_bit_addr,
   input  logic [11:0]   length_bits,
   input  logic          out_free,
   input  logic [7:0]    dst_rd,
   input  logic [7:0]    merged,
   output mem_req_type   mem_req,
   output merge_ctl_type merge_ctl,
   output rsp_load_type  rsp_load
);

   state_type         state_ff, state_in;
   logic [2:0]        shift_ff, shift_in;
   logic [ADDR_W-1:0] s0_ff, s0_in;
   logic [ADDR_W-1:0] d_ff, d_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [7:0]        head_mask_ff, head_mask_in;
   logic [7:0]        tail_mask_ff, tail_mask_in;
   logic              first_ff, first_in;
   logic              rd_fits_ff, rd_fits_in;

   logic              accept;
   logic              byte_fits;
   logic [LEN_W:0]    src_end;
   logic [LEN_W:0]    dst_end;
   logic              refuse;
   logic [BIT_W-1:0]  last_bit;
   logic [BIT_W:0]    s0_diff;
   logic [7:0]        mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      s0_ff        <= s0_in;
      d_ff         <= d_in;
      last_ff      <= last_in;
      head_mask_ff <= head_mask_in;
      tail_mask_ff <= tail_mask_in;
      first_ff     <= first_in;
      rd_fits_ff   <= rd_fits_in;
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE) && out_free;
      accept    = req_valid && req_ready;
      byte_fits = int'(byte_addr) < STORE_BYTES;

      src_end  = (LEN_W + 1)'(src_bit_addr) + (LEN_W + 1)'(length_bits);
      dst_end  = (LEN_W + 1)'(dst_bit_addr) + (LEN_W + 1)'(length_bits);
      refuse   = (src_end > (LEN_W + 1)'(BIT_LIMIT)) ||
                 (dst_end > (LEN_W + 1)'(BIT_LIMIT));
      last_bit = BIT_W'(dst_end - (LEN_W + 1)'(1));
      // first source byte feeding the first destination byte, may wrap below zero
      s0_diff  = (BIT_W + 1)'(src_bit_addr) - (BIT_W + 1)'(dst_bit_addr[2:0]);

      mask = (first_ff ? head_mask_ff : 8'hFF) &
             ((d_ff == last_ff) ? tail_mask_ff : 8'hFF);

      state_in     = state_ff;
      shift_in     = shift_ff;
      s0_in        = s0_ff;
      d_in         = d_ff;
      last_in      = last_ff;
      head_mask_in = head_mask_ff;
      tail_mask_in = tail_mask_ff;
      first_in     = first_ff;
      rd_fits_in   = rd_fits_ff;

      mem_req.src_we       = 1'b0;
      mem_req.dst_we       = 1'b0;
      mem_req.waddr        = ADDR_W'(byte_addr);
      mem_req.wdata        = byte_data;
      mem_req.src_raddr_lo = s0_ff;
      mem_req.src_raddr_hi = s0_ff + ADDR_W'(1);
      mem_req.dst_raddr    = d_ff;

      merge_ctl.shift = shift_ff;
      merge_ctl.mask  = mask;

      rsp_load.load      = 1'b0;
      rsp_load.read_data = 8'd0;
      rsp_load.status    = STATUS_OK;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_WR_SRC: begin
                     mem_req.src_we = byte_fits;
                     rsp_load.load  = 1'b1;
                  end
                  CMD_WR_DST: begin
                     mem_req.dst_we = byte_fits;
                     rsp_load.load  = 1'b1;
                  end
                  CMD_RD_DST: begin
                     mem_req.dst_raddr = ADDR_W'(byte_addr);
                     rd_fits_in        = byte_fits;
                     state_in          = ST_READ;
                  end
                  CMD_COPY: begin
                     if (refuse) begin
                        rsp_load.load   = 1'b1;
                        rsp_load.status = STATUS_REFUSED;
                     end else if (length_bits == 12'd0) begin
                        rsp_load.load = 1'b1;
                     end else begin
                        shift_in     = src_bit_addr[2:0] - dst_bit_addr[2:0];
                        s0_in        = s0_diff[BIT_W-1:3];
                        d_in         = dst_bit_addr[BIT_W-1:3];
                        last_in      = last_bit[BIT_W-1:3];
                        head_mask_in = 8'hFF << dst_bit_addr[2:0];
                        tail_mask_in = 8'hFF >> (3'd7 - last_bit[2:0]);
                        first_in     = 1'b1;
                        state_in     = ST_COPY_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load.load      = 1'b1;
            rsp_load.read_data = rd_fits_ff ? dst_rd : 8'd0;
            state_in           = ST_IDLE;
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            mem_req.dst_we = 1'b1;
            mem_req.waddr  = d_ff;
            mem_req.wdata  = merged;
            if (d_ff == last_ff) begin
               rsp_load.load = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               d_in     = d_ff + ADDR_W'(1);
               s0_in    = s0_ff + ADDR_W'(1);
               first_in = 1'b0;
               state_in = ST_COPY_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a result is only loaded when the output register can take it
   assert property (@(posedge clock) disable iff (reset) rsp_load.load |-> out_free)
      else $error("result loaded into a full output register");

   // each read phase of the copy walk is followed by its write phase
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY_RD |=> state_ff == ST_COPY_WR)
      else $error("copy read phase not followed by write phase");

   // the walk never passes the last destination byte
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY_WR |-> d_ff <= last_ff)
      else $error("copy walk ran past the last destination byte");

   // a destination read phase follows an accepted item
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> $past(accept))
      else $error("read phase without an accepted item");

endmodule

/* hw/rtl/unaligned_bit_copy_top.sv */
// top level of the unaligned bit copy engine with its result register
// byte writes and refused or empty copies give their result in the cycle after accept
// a byte read goes through the registered destination store read and ST_READ before its result is registered
// a copy visits each destination byte it touches with one store read, then one merge and write
// one item at a time; the next item is taken once the result register is free or draining
// reset idles the sequencer and empties the result register; both stores are undefined until written
module unaligned_bit_copy_top
   import ubc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [55:0] req_tdata,   // byte_addr, byte_data, src_bit_addr, dst_bit_addr,
                                    // length_bits, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // read_data, status, zero pad
);

   // unpacked request fields
   cmd_type       cmd;
   logic [7:0]    byte_addr;
   logic [7:0]    byte_data;
   logic [10:0]   src_bit_addr;
   logic [10:0]   dst_bit_addr;
   logic [11:0]   length_bits;

   mem_req_type   mem_req;
   merge_ctl_type merge_ctl;
   rsp_load_type  rsp_load;
   logic [7:0]    src_lo;
   logic [7:0]    src_hi;
   logic [7:0]    dst_rd;
   logic [7:0]    merged;
   logic          out_free;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_read_ff, rsp_read_in;
   logic          rsp_status_ff, rsp_status_in;

   assign cmd          = cmd_type'(req_tuser);
   assign byte_addr    = req_tdata[7:0];
   assign byte_data    = req_tdata[15:8];
   assign src_bit_addr = req_tdata[26:16];
   assign dst_bit_addr = req_tdata[37:27];
   assign length_bits  = req_tdata[49:38];

   // free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   ubc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .cmd          (cmd),
      .byte_addr    (byte_addr),
      .byte_data    (byte_data),
      .src_bit_addr (src_bit_addr),
      .dst_bit_addr (dst_bit_addr),
      .length_bits  (length_bits),
      .out_free     (out_free),
      .dst_rd       (dst_rd),
      .merged       (merged),
      .mem_req      (mem_req),
      .merge_ctl    (merge_ctl),
      .rsp_load     (rsp_load)
   );

   ubc_stores u_stores (
      .clock   (clock),
      .mem_req (mem_req),
      .src_lo  (src_lo),
      .src_hi  (src_hi),
      .dst_rd  (dst_rd)
   );

   // funnel shift unit: aligns two source bytes onto one destination byte
   ubc_funnel u_funnel (
      .ctl     (merge_ctl),
      .src_lo  (src_lo),
      .src_hi  (src_hi),
      .dst_old (dst_rd),
      .dst_new (merged)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load.load) begin
         rsp_valid_in  = 1'b1;
         rsp_read_in   = rsp_load.read_data;
         rsp_status_in = rsp_load.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_ff   <= rsp_read_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_read_ff};

endmodule
